>>> rtl/core/svmp_pkg.sv
package svmp_pkg;

  localparam logic [31:0] PI28 = 32'd843314857;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_code_t;

  typedef struct packed {
    op_code_t    op;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] duration;
    logic [16:0] dt;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        moving;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MV_DIF,
    S_MV_AX,
    S_MV_SQ,
    S_MV_SQRT,
    S_MV_CHK,
    S_MV_DEN,
    S_MV_DIV,
    S_TK_CHK,
    S_TK_W,
    S_TK_SQRT,
    S_TK_FDIV,
    S_TK_SPD,
    S_TK_TRV,
    S_TK_MX,
    S_TK_DX,
    S_TK_MY,
    S_TK_DY,
    S_TK_END,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    U_SQRT,
    U_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
    logic [6:0] steps;
  } unit_ctl_t;

endpackage

>>> rtl/core/svmp_unit.sv
module svmp_unit (
  input  logic                clk,
  input  logic                rst,
  input  svmp_pkg::unit_ctl_t ctl,
  input  logic [127:0]        num,
  input  logic [63:0]         den,
  output logic [63:0]         res,
  output logic                done
);

  svmp_pkg::unit_op_t op;
  logic [127:0] sh;
  logic [67:0]  rem;
  logic [63:0]  q;
  logic [63:0]  d;
  logic [6:0]   cnt;
  logic         run;
  logic [67:0]  rem_next;
  logic [67:0]  trial;
  logic [63:0]  q_next;

  always_comb begin
    rem_next = rem;
    q_next = q;
    trial = '0;
    case (op)
      svmp_pkg::U_SQRT: begin
        rem_next = {rem[65:0], sh[127:126]};
        trial = {2'b0, q, 2'b01};
        if (rem_next >= trial) begin
          rem_next = rem_next - trial;
          q_next = {q[62:0], 1'b1};
        end else begin
          q_next = {q[62:0], 1'b0};
        end
      end
      default: begin
        rem_next = {rem[66:0], sh[127]};
        trial = {4'b0, d};
        if (rem_next >= trial) begin
          rem_next = rem_next - trial;
          q_next = {q[62:0], 1'b1};
        end else begin
          q_next = {q[62:0], 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
      end else if (run && cnt == 7'd1) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
    if (ctl.start) begin
      op <= ctl.op;
      sh <= num;
      d <= den;
      rem <= '0;
      q <= '0;
      cnt <= ctl.steps;
    end else if (run) begin
      rem <= rem_next;
      q <= q_next;
      sh <= (op == svmp_pkg::U_SQRT) ? {sh[125:0], 2'b0} : {sh[126:0], 1'b0};
      cnt <= cnt - 7'd1;
    end
  end

  assign res = q;

endmodule

>>> rtl/core/semicircle_velocity_move_profile_core.sv
// Point-to-point 2D move generator with a semicircular speed profile, in signed
// Q16.16. An item with op 1 starts a move toward target over duration; an item with
// op 0 advances the move by dt seconds. Each item yields one result with the
// position and the moving flag. One shared bit-serial unit does every square root
// and division, one bit per cycle, and one 33x33 multiplier is reused over steps.
// A move runs 33 root steps and then 79 divide steps; the divide is skipped when the
// peak speed saturates and for a zero distance or a zero duration. A tick while
// moving with a nonzero half time runs 32 root steps, 48 divide steps and two 66-step
// divides, the last two skipped for a zero distance; a tick that ends a move or comes
// while idle does not use the unit. The block takes no new item until the result is
// taken.
module semicircle_velocity_move_profile_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svmp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output svmp_pkg::out_item_t  out_data
);

  svmp_pkg::state_t state, state_next;
  svmp_pkg::in_item_t item;
  svmp_pkg::unit_ctl_t uctl;

  logic signed [31:0] cur_x, cur_y, start_x, start_y, goal_x, goal_y;
  logic [31:0] elapsed, total_time, half_time, peak_speed;
  logic [33:0] span;
  logic        busy;
  logic signed [32:0] tdx, tdy;
  logic signed [32:0] ddx, ddy;
  logic [32:0] abs_dx, abs_dy;
  logic [65:0] acc;
  logic [63:0] tmp;
  logic [31:0] factor;
  logic [32:0] travel;
  logic [31:0] ae, ae_next;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic        peak_sat;
  logic [127:0] unum;
  logic [63:0]  uden;
  logic [63:0]  ures;
  logic         udone;
  logic signed [33:0] step_v;
  logic signed [34:0] sum_v;
  logic signed [31:0] sat_v;
  logic signed [32:0] e_s;
  logic [32:0] el_sum;

  assign ddx = {goal_x[31], goal_x} - {start_x[31], start_x};
  assign ddy = {goal_y[31], goal_y} - {start_y[31], start_y};
  assign abs_dx = (tdx < 0) ? 33'(-tdx) : 33'(tdx);
  assign abs_dy = (tdy < 0) ? 33'(-tdy) : 33'(tdy);
  assign e_s = $signed({1'b0, elapsed}) - $signed({1'b0, half_time});
  assign ae_next = (e_s < 0) ? ((-e_s > $signed({1'b0, half_time})) ? half_time : 32'(-e_s))
                             : ((e_s > $signed({1'b0, half_time})) ? half_time : 32'(e_s));
  assign el_sum = {1'b0, elapsed} + {16'b0, item.dt};
  assign peak_sat = ({17'b0, span, 13'b0} >= tmp);

  assign in_ready = (state == svmp_pkg::S_IDLE);
  assign out_valid = (state == svmp_pkg::S_OUT);
  assign out_data = '{pos_x: cur_x, pos_y: cur_y, moving: busy};

  svmp_unit u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .num(unum), .den(uden), .res(ures), .done(udone)
  );

  always_comb begin
    state_next = state;
    case (state)
      svmp_pkg::S_IDLE:
        if (in_valid) begin
          state_next = (in_data.op == svmp_pkg::OP_MOVE) ? svmp_pkg::S_MV_DIF
                                                         : svmp_pkg::S_TK_CHK;
        end
      svmp_pkg::S_MV_DIF:  state_next = svmp_pkg::S_MV_AX;
      svmp_pkg::S_MV_AX:   state_next = svmp_pkg::S_MV_SQ;
      svmp_pkg::S_MV_SQ:   state_next = svmp_pkg::S_MV_SQRT;
      svmp_pkg::S_MV_SQRT: if (udone) state_next = svmp_pkg::S_MV_CHK;
      svmp_pkg::S_MV_CHK:
        if (span == 34'd0 || item.duration == 32'd0) state_next = svmp_pkg::S_OUT;
        else state_next = svmp_pkg::S_MV_DEN;
      svmp_pkg::S_MV_DEN:
        if (peak_sat) state_next = svmp_pkg::S_OUT;
        else state_next = svmp_pkg::S_MV_DIV;
      svmp_pkg::S_MV_DIV:  if (udone) state_next = svmp_pkg::S_OUT;
      svmp_pkg::S_TK_CHK:
        if (!busy) state_next = svmp_pkg::S_OUT;
        else if (elapsed >= total_time || half_time == 32'd0) state_next = svmp_pkg::S_TK_END;
        else state_next = svmp_pkg::S_TK_W;
      svmp_pkg::S_TK_W:    state_next = svmp_pkg::S_TK_SQRT;
      svmp_pkg::S_TK_SQRT: if (udone) state_next = svmp_pkg::S_TK_FDIV;
      svmp_pkg::S_TK_FDIV: if (udone) state_next = svmp_pkg::S_TK_SPD;
      svmp_pkg::S_TK_SPD:  state_next = svmp_pkg::S_TK_TRV;
      svmp_pkg::S_TK_TRV:
        if (span == 34'd0) state_next = svmp_pkg::S_TK_END;
        else state_next = svmp_pkg::S_TK_MX;
      svmp_pkg::S_TK_MX:   state_next = svmp_pkg::S_TK_DX;
      svmp_pkg::S_TK_DX:   if (udone) state_next = svmp_pkg::S_TK_MY;
      svmp_pkg::S_TK_MY:   state_next = svmp_pkg::S_TK_DY;
      svmp_pkg::S_TK_DY:   if (udone) state_next = svmp_pkg::S_TK_END;
      svmp_pkg::S_TK_END:  state_next = svmp_pkg::S_OUT;
      svmp_pkg::S_OUT:     if (out_ready) state_next = svmp_pkg::S_IDLE;
      default:             state_next = svmp_pkg::S_IDLE;
    endcase
  end

  // Shared multiplier operands, one product per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      svmp_pkg::S_MV_AX: begin
        mul_a = abs_dx;
        mul_b = abs_dx;
      end
      svmp_pkg::S_MV_SQ: begin
        mul_a = abs_dy;
        mul_b = abs_dy;
      end
      svmp_pkg::S_MV_CHK: begin
        mul_a = {2'b0, item.duration[31:1]};
        mul_b = {1'b0, svmp_pkg::PI28};
      end
      svmp_pkg::S_TK_W: begin
        mul_a = {1'b0, half_time - ae};
        mul_b = {1'b0, half_time} + {1'b0, ae};
      end
      svmp_pkg::S_TK_SPD: begin
        mul_a = {1'b0, peak_speed};
        mul_b = {1'b0, factor};
      end
      svmp_pkg::S_TK_TRV: begin
        mul_a = {1'b0, tmp[47:16]};
        mul_b = {16'b0, item.dt};
      end
      svmp_pkg::S_TK_MX: begin
        mul_a = abs_dx;
        mul_b = travel;
      end
      svmp_pkg::S_TK_MY: begin
        mul_a = abs_dy;
        mul_b = travel;
      end
      default: ;
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  always_comb begin
    uctl = '{start: 1'b0, op: svmp_pkg::U_SQRT, steps: 7'd0};
    unum = '0;
    uden = '0;
    case (state)
      svmp_pkg::S_MV_SQ: begin
        uctl = '{start: 1'b1, op: svmp_pkg::U_SQRT, steps: 7'd33};
        unum = {acc + mul_p, 62'b0};
      end
      svmp_pkg::S_MV_DEN:
        if (!peak_sat) begin
          uctl = '{start: 1'b1, op: svmp_pkg::U_DIV, steps: 7'd79};
          unum = {span, 45'b0, 49'b0};
          uden = tmp;
        end
      svmp_pkg::S_TK_W: begin
        uctl = '{start: 1'b1, op: svmp_pkg::U_SQRT, steps: 7'd32};
        unum = {mul_p[63:0], 64'b0};
      end
      svmp_pkg::S_TK_SQRT:
        if (udone) begin
          uctl = '{start: 1'b1, op: svmp_pkg::U_DIV, steps: 7'd48};
          unum = {ures[31:0], 96'b0};
          uden = {32'b0, half_time};
        end
      svmp_pkg::S_TK_MX: begin
        uctl = '{start: 1'b1, op: svmp_pkg::U_DIV, steps: 7'd66};
        unum = {mul_p, 62'b0};
        uden = {30'b0, span};
      end
      svmp_pkg::S_TK_MY: begin
        uctl = '{start: 1'b1, op: svmp_pkg::U_DIV, steps: 7'd66};
        unum = {mul_p, 62'b0};
        uden = {30'b0, span};
      end
      default: ;
    endcase
  end

  always_comb begin
    step_v = (tdx < 0) ? -$signed({1'b0, ures[32:0]}) : $signed({1'b0, ures[32:0]});
    if (state == svmp_pkg::S_TK_DY)
      step_v = (tdy < 0) ? -$signed({1'b0, ures[32:0]}) : $signed({1'b0, ures[32:0]});
    sum_v = (state == svmp_pkg::S_TK_DY) ? (35'(cur_y) + 35'(step_v))
                                        : (35'(cur_x) + 35'(step_v));
    if (sum_v > 35'sd2147483647) sat_v = 32'sh7FFFFFFF;
    else if (sum_v < -35'sd2147483648) sat_v = 32'sh80000000;
    else sat_v = sum_v[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svmp_pkg::S_IDLE;
      cur_x <= '0; cur_y <= '0; start_x <= '0; start_y <= '0;
      goal_x <= '0; goal_y <= '0;
      elapsed <= '0; total_time <= '0; half_time <= '0; peak_speed <= '0;
      span <= '0;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        svmp_pkg::S_IDLE:
          if (in_valid) begin
            item <= in_data;
            if (in_data.op == svmp_pkg::OP_MOVE) begin
              start_x <= cur_x;
              start_y <= cur_y;
              goal_x <= in_data.target_x;
              goal_y <= in_data.target_y;
            end
          end
        svmp_pkg::S_MV_DIF: begin
          tdx <= ddx;
          tdy <= ddy;
        end
        svmp_pkg::S_MV_SQRT:
          if (udone) span <= ures[33:0];
        svmp_pkg::S_MV_CHK:
          if (span != 34'd0) begin
            elapsed <= '0;
            total_time <= item.duration;
            half_time <= {1'b0, item.duration[31:1]};
            if (item.duration == 32'd0) begin
              cur_x <= item.target_x;
              cur_y <= item.target_y;
            end
          end
        svmp_pkg::S_MV_DEN:
          if (peak_sat) begin
            peak_speed <= 32'hFFFFFFFF;
            busy <= 1'b1;
          end
        svmp_pkg::S_MV_DIV:
          if (udone) begin
            peak_speed <= ures[31:0];
            busy <= 1'b1;
          end
        svmp_pkg::S_TK_CHK: begin
          ae <= ae_next;
          if (busy && elapsed >= total_time) begin
            busy <= 1'b0;
            cur_x <= goal_x;
            cur_y <= goal_y;
          end
        end
        svmp_pkg::S_TK_FDIV:
          if (udone) factor <= ures[31:0];
        svmp_pkg::S_TK_DX:
          if (udone) cur_x <= sat_v;
        svmp_pkg::S_TK_DY:
          if (udone) cur_y <= sat_v;
        svmp_pkg::S_TK_END:
          elapsed <= el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      svmp_pkg::S_MV_AX:  acc <= mul_p;
      svmp_pkg::S_MV_CHK: tmp <= mul_p[63:0];
      svmp_pkg::S_TK_SPD: tmp <= mul_p[63:0];
      svmp_pkg::S_TK_TRV: travel <= mul_p[48:16];
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted twice");

endmodule

>>> sim/testbench.sv
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  svmp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  svmp_pkg::out_item_t out_data;

  localparam longint unsigned PI_Q28 = 64'd843314857;
  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam int NUM_RANDOM = 1800;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  semicircle_velocity_move_profile_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predicted motion state.
  longint m_cur_x, m_cur_y, m_start_x, m_start_y, m_goal_x, m_goal_y;
  longint unsigned m_elapsed, m_total, m_half, m_peak, m_dist;
  bit m_busy;

  svmp_pkg::out_item_t expected_positions[$];
  int mismatches = 0;
  longint cycles = 0;
  bit idle_free = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(logic [65:0] v);
    logic [65:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
      trial = (root << 2) | 66'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 66'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint axis_advance(longint d, longint unsigned travel);
    logic [127:0] prod;
    longint unsigned mag;
    longint s;
    if (m_dist == 0) return 0;
    mag = (d < 0) ? -d : d;
    prod = 128'(mag) * 128'(travel);
    s = longint'(prod / 128'(m_dist));
    return (d < 0) ? -s : s;
  endfunction

  function automatic void predict_reset();
    m_cur_x = 0; m_cur_y = 0; m_start_x = 0; m_start_y = 0;
    m_goal_x = 0; m_goal_y = 0;
    m_elapsed = 0; m_total = 0; m_half = 0; m_peak = 0; m_dist = 0;
    m_busy = 1'b0;
  endfunction

  function automatic svmp_pkg::out_item_t predict_position(svmp_pkg::in_item_t it);
    longint dx, dy, e;
    longint unsigned ax, ay, den, factor, speed, travel, ae, w;
    logic [65:0] sumsq;
    svmp_pkg::out_item_t r;
    if (it.op == svmp_pkg::OP_MOVE) begin
      m_start_x = m_cur_x;
      m_start_y = m_cur_y;
      m_goal_x = longint'($signed(it.target_x));
      m_goal_y = longint'($signed(it.target_y));
      dx = m_goal_x - m_start_x;
      dy = m_goal_y - m_start_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sumsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      m_dist = int_sqrt(sumsq);
      if (m_dist != 0) begin
        m_elapsed = 0;
        m_total = it.duration;
        m_half = it.duration >> 1;
        if (it.duration == 0) begin
          m_cur_x = m_goal_x;
          m_cur_y = m_goal_y;
        end else begin
          den = m_half * PI_Q28;
          if ((m_dist << 13) >= den) m_peak = MASK32;
          else m_peak = 64'((128'(m_dist) << 45) / 128'(den));
          m_busy = 1'b1;
        end
      end
    end else if (m_busy) begin
      if (m_elapsed >= m_total) begin
        m_busy = 1'b0;
        m_cur_x = m_goal_x;
        m_cur_y = m_goal_y;
      end else begin
        factor = 0;
        if (m_half != 0) begin
          e = longint'(m_elapsed) - longint'(m_half);
          ae = (e < 0) ? -e : e;
          if (ae > m_half) ae = m_half;
          w = (m_half - ae) * (m_half + ae);
          factor = (int_sqrt(66'(w)) << 16) / m_half;
        end
        speed = (m_peak * factor) >> 16;
        travel = (speed * it.dt) >> 16;
        m_cur_x = sat32(m_cur_x + axis_advance(m_goal_x - m_start_x, travel));
        m_cur_y = sat32(m_cur_y + axis_advance(m_goal_y - m_start_y, travel));
      end
      m_elapsed = m_elapsed + it.dt;
      if (m_elapsed > MASK32) m_elapsed = MASK32;
    end
    r.pos_x = m_cur_x[31:0];
    r.pos_y = m_cur_y[31:0];
    r.moving = m_busy;
    return r;
  endfunction

  function automatic svmp_pkg::in_item_t make_move(logic [31:0] tx, logic [31:0] ty,
                                                   logic [31:0] dur);
    svmp_pkg::in_item_t it;
    it = '0;
    it.op = svmp_pkg::OP_MOVE;
    it.target_x = tx;
    it.target_y = ty;
    it.duration = dur;
    it.dt = 17'($urandom);
    return it;
  endfunction

  function automatic svmp_pkg::in_item_t make_tick(logic [16:0] dt);
    svmp_pkg::in_item_t it;
    it.op = svmp_pkg::OP_TICK;
    it.target_x = $urandom;
    it.target_y = $urandom;
    it.duration = $urandom;
    it.dt = dt;
    return it;
  endfunction

  task automatic send_item(svmp_pkg::in_item_t it, bit known, svmp_pkg::out_item_t res);
    svmp_pkg::out_item_t pred;
    while (!idle_free && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_position(it);
    expected_positions.push_back(known ? res : pred);
  endtask

  // Directed rows; known results are typed in, the rest come from the predictor.
  typedef struct {
    svmp_pkg::in_item_t  item;
    bit                  known;
    svmp_pkg::out_item_t result;
  } directed_row_t;

  directed_row_t rows[$];

  task automatic add_row(svmp_pkg::in_item_t it, bit known, svmp_pkg::out_item_t res);
    directed_row_t row;
    row.item = it;
    row.known = known;
    row.result = res;
    rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 33);
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", out_data);
        end else begin
          if (out_data !== expected_positions[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p, got %p", expected_positions[0], out_data);
          end
          void'(expected_positions.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    svmp_pkg::in_item_t it;
    int n;
    int kind;
    logic [31:0] bx, by;
    predict_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(make_tick(17'd65536), 1'b1, '{32'd0, 32'd0, 1'b0});
    add_row(make_move(32'd0, 32'd0, 32'd100), 1'b1, '{32'd0, 32'd0, 1'b0});
    add_row(make_move(32'h0001_0000, 32'h0002_0000, 32'd0), 1'b1,
            '{32'h0001_0000, 32'h0002_0000, 1'b0});
    add_row(make_move(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000), 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(make_tick(17'h0_2000), 1'b0, '0);
    add_row(make_tick(17'd0), 1'b0, '0);
    add_row(make_tick(17'd65536), 1'b0, '0);
    add_row(make_tick(17'd1), 1'b0, '0);
    add_row(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1), 1'b0, '0);
    add_row(make_tick(17'd65536), 1'b0, '0);
    add_row(make_tick(17'd65536), 1'b0, '0);
    add_row(make_move(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(make_tick(17'd65536), 1'b0, '0);
    add_row(make_tick(17'h1_FFFF & 17'd65535), 1'b0, '0);
    add_row(make_move(32'h0000_1000, 32'h8000_0000, 32'd0), 1'b0, '0);
    add_row(make_tick(17'd500), 1'b0, '0);
    add_row(make_tick(17'd500), 1'b0, '0);
    add_row(make_move(32'h0010_0000, 32'h0000_0000, 32'h0004_0000), 1'b0, '0);
    add_row(make_tick(17'h1_0000), 1'b0, '0);

    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].known, rows[i].result);
    end

    n = 0;
    while (n < NUM_RANDOM) begin
      idle_free = (n >= 600 && n < 800);
      kind = $urandom_range(99);
      if (kind < 8 || !m_busy && kind < 40) begin
        bx = (kind % 3 == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        by = (kind % 5 == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        if ($urandom_range(19) == 0) begin
          bx = m_cur_x[31:0];
          by = m_cur_y[31:0];
        end
        case ($urandom_range(5))
          0: it = make_move(bx, by, 32'd0);
          1: it = make_move(bx, by, $urandom);
          2: it = make_move(bx, by, $urandom_range(3));
          default: it = make_move(bx, by, $urandom_range(32'h0008_0000, 32'h0000_4000));
        endcase
      end else begin
        case ($urandom_range(5))
          0: it = make_tick(17'($urandom));
          1: it = make_tick(17'd65536);
          2: it = make_tick(17'($urandom_range(3)));
          default: it = make_tick(17'($urandom_range(32'h4000, 32'h0400)));
        endcase
      end
      send_item(it, 1'b0, '0);
      n++;
    end
    in_valid <= 1'b0;
    idle_free = 1'b0;

    while (expected_positions.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
